// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top-level module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fbmd_pkg.sv =====
// types, constants and log2 tables for the fft bin level pipeline
package fbmd_pkg;

	localparam int POWER_W = 64;
	localparam int POS_W   = 6;
	localparam int SEG_W   = 4;
	localparam int REM_W   = 16;
	localparam int DIFF_W  = 13;
	localparam int IPROD_W = DIFF_W + REM_W;
	localparam int L_W     = 23;
	localparam int NET_W   = 24;
	localparam int PROD_W  = 42;
	localparam int LVL_SHIFT = 24;
	localparam int LVL_W   = PROD_W + 1 - LVL_SHIFT;
	localparam int LANE_STAGES = 6;

	// 10*log10(2) in unsigned Q16
	localparam int DB_PER_LOG2_Q16 = 197283;
	localparam int LEVEL_MAX = 32767;
	localparam int FLOOR_RESET = -25600;

	// register index codes
	localparam logic REG_FLOOR_DB = 1'b0;

	typedef logic [POWER_W-1:0] power_t;
	typedef logic signed [15:0] level_t;
	typedef logic [9:0]         bin_t;

	typedef struct packed {
		logic pair0;
		bin_t bin;
	} meta_t;

	// log2(1+i/16) in Q16 at segment starts, and the step to the next start
	localparam logic [15:0] LOG2_BASE [16] = '{
		16'd0,     16'd5732,  16'd11136, 16'd16248,
		16'd21098, 16'd25711, 16'd30109, 16'd34312,
		16'd38336, 16'd42196, 16'd45904, 16'd49472,
		16'd52911, 16'd56229, 16'd59434, 16'd62534
	};
	localparam logic [DIFF_W-1:0] LOG2_DIFF [16] = '{
		13'd5732, 13'd5404, 13'd5112, 13'd4850,
		13'd4613, 13'd4398, 13'd4203, 13'd4024,
		13'd3860, 13'd3708, 13'd3568, 13'd3439,
		13'd3318, 13'd3205, 13'd3100, 13'd3002
	};

	// elaboration-time log2 in Q16 of a nonzero constant
	function automatic int log2_q16(input longint unsigned v);
		int unsigned pos;
		longint unsigned norm;
		int unsigned seg;
		int unsigned rem;
		pos = 0;
		for (int i = 0; i < POWER_W; i++) begin
			if (v[i]) pos = i;
		end
		norm = v << (63 - pos);
		seg = int'(norm[62:59]);
		rem = int'(norm[58:43]);
		return int'(pos << 16) + int'(LOG2_BASE[seg]) +
			int'((int'(LOG2_DIFF[seg]) * rem) >> 16);
	endfunction

endpackage

// ===== rtl/fbmd_in_if.sv =====
// input channel: one packed fft pair per beat
interface fbmd_in_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] real_part;
	logic signed [31:0] imag_part;
	logic [8:0]        pair_index;

	modport source (output valid, output real_part, output imag_part, output pair_index,
		input ready);
	modport sink (input valid, input real_part, input imag_part, input pair_index,
		output ready);
endinterface

// ===== rtl/fbmd_out_if.sv =====
// output channel: one bin level per beat
interface fbmd_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         bin_index;
	logic signed [15:0] level_db;
	logic               last_of_item;

	modport source (output valid, output bin_index, output level_db, output last_of_item,
		input ready);
	modport sink (input valid, input bin_index, input level_db, input last_of_item,
		output ready);
endinterface

// ===== rtl/fbmd_lane.sv =====
// pipelined power to dB level lane: leading one, normalize, log2 table, offset, scale, floor and clamp
module fbmd_lane #(
	parameter int OFFSET_Q16 = 1966080
) (
	input  logic                                clk,
	input  logic [fbmd_pkg::LANE_STAGES-1:0]    en,
	input  fbmd_pkg::power_t                    power,
	input  fbmd_pkg::level_t                    floor_db,
	output fbmd_pkg::level_t                    level
);

	localparam logic signed [fbmd_pkg::NET_W-1:0] OFFSET_NET =
		fbmd_pkg::NET_W'(OFFSET_Q16);
	localparam logic signed [fbmd_pkg::PROD_W-1:0] DB_K =
		fbmd_pkg::PROD_W'(fbmd_pkg::DB_PER_LOG2_Q16);
	localparam logic signed [fbmd_pkg::PROD_W:0] ROUND_HALF =
		(fbmd_pkg::PROD_W+1)'(1) <<< (fbmd_pkg::LVL_SHIFT - 1);
	localparam logic signed [fbmd_pkg::LVL_W-1:0] LVL_MAX =
		fbmd_pkg::LVL_W'(fbmd_pkg::LEVEL_MAX);

	logic [fbmd_pkg::POS_W-1:0]   pos_c;
	fbmd_pkg::power_t             norm_c;
	logic [fbmd_pkg::L_W-1:0]     l_c;
	logic signed [fbmd_pkg::PROD_W-1:0] mul_c;
	logic signed [fbmd_pkg::PROD_W:0]   rnd_c;
	logic signed [fbmd_pkg::LVL_W-1:0]  lvl_c;
	logic signed [fbmd_pkg::LVL_W-1:0]  fl_c;
	fbmd_pkg::level_t             res_c;

	fbmd_pkg::power_t             val_s3;
	logic [fbmd_pkg::POS_W-1:0]   pos_s3, pos_s4, pos_s5;
	logic                         zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic [fbmd_pkg::SEG_W-1:0]   seg_s4;
	logic [fbmd_pkg::REM_W-1:0]   rem_s4;
	logic [fbmd_pkg::IPROD_W-1:0] iprod_s5;
	logic [15:0]                  base_s5;
	logic signed [fbmd_pkg::NET_W-1:0]  net_s6;
	logic signed [fbmd_pkg::PROD_W-1:0] mul_s7;
	fbmd_pkg::level_t             level_s8;

	// leading one position
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < fbmd_pkg::POWER_W; i++) begin
			if (power[i]) pos_c = fbmd_pkg::POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			val_s3  <= power;
			pos_s3  <= pos_c;
			zero_s3 <= (power == '0);
		end
	end

	// normalize and split into segment and remainder
	assign norm_c = val_s3 << (6'd63 - pos_s3);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			seg_s4  <= norm_c[62:59];
			rem_s4  <= norm_c[58:43];
			pos_s4  <= pos_s3;
			zero_s4 <= zero_s3;
		end
	end

	// table lookup and interpolation product
	always_ff @(posedge clk) begin
		if (en[2]) begin
			iprod_s5 <= fbmd_pkg::IPROD_W'(fbmd_pkg::LOG2_DIFF[seg_s4]) *
				fbmd_pkg::IPROD_W'(rem_s4);
			base_s5  <= fbmd_pkg::LOG2_BASE[seg_s4];
			pos_s5   <= pos_s4;
			zero_s5  <= zero_s4;
		end
	end

	// log2 in Q16 less the full-scale offset
	assign l_c = fbmd_pkg::L_W'({pos_s5, 16'b0}) + fbmd_pkg::L_W'(base_s5) +
		fbmd_pkg::L_W'(iprod_s5[fbmd_pkg::IPROD_W-1:16]);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			net_s6  <= signed'({1'b0, l_c}) - OFFSET_NET;
			zero_s6 <= zero_s5;
		end
	end

	// scale log2 to dB
	assign mul_c = fbmd_pkg::PROD_W'(net_s6) * DB_K;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mul_s7  <= mul_c;
			zero_s7 <= zero_s6;
		end
	end

	// round to q8.8, floor and saturate
	assign rnd_c = (fbmd_pkg::PROD_W+1)'(mul_s7) + ROUND_HALF;
	assign lvl_c = signed'(rnd_c[fbmd_pkg::PROD_W:fbmd_pkg::LVL_SHIFT]);
	assign fl_c  = fbmd_pkg::LVL_W'(floor_db);

	always_comb begin
		if (zero_s7 || lvl_c < fl_c) begin
			res_c = floor_db;
		end else if (lvl_c > LVL_MAX) begin
			res_c = 16'sd32767;
		end else begin
			res_c = lvl_c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			level_s8 <= res_c;
		end
	end

	assign level = level_s8;

endmodule

// ===== rtl/fft_bin_magnitude_db.sv =====
// FFT bin level meter: takes one packed real-FFT pair per beat and returns each bin's
// power level in Q8.8 dBFS. Sustained rate is one pair per clock while the output is
// ready, through an eight-stage pipeline (squares, sum, leading-one detect, normalize,
// log2 table, offset, dB scale, floor and clamp); the first result of a pair is offered
// once the pair reaches the last stage. Pair 0 carries DC and Nyquist and returns two
// beats (bin 0, then bin FRAME_LEN/2), so the output register holds it for both beats;
// the second beat reaches the input as backpressure once per frame unless a bubble in the
// pipeline absorbs it. Stages fill bubbles while the output waits. The floor register
// sits at APB address 0 and may be written only while the pipeline is empty.
`include "assert_macros.svh"

module fft_bin_magnitude_db #(
	parameter int FRAME_LEN        = 1024,
	parameter int SAMPLE_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	fbmd_in_if.sink     data_in,
	fbmd_out_if.source  data_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NSTG = 8;
	localparam int HALF = FRAME_LEN / 2;
	localparam int OFFSET_Q16 = 2 * SAMPLE_FRAC_BITS * 65536 +
		2 * fbmd_pkg::log2_q16(64'(HALF));
	localparam fbmd_pkg::bin_t HALF_BIN = 10'(HALF);

	fbmd_pkg::level_t floor_q;
	logic             sec_q;
	logic             last_c;
	logic             take_last_c;
	logic [NSTG:1]    stg_en;
	logic [NSTG:1]    stg_vld_s;
	fbmd_pkg::meta_t  stg_meta_s [1:NSTG];
	fbmd_pkg::meta_t  meta_in_c;
	logic signed [63:0] pr_c, pi_c;
	fbmd_pkg::power_t pr_s1, pi_s1;
	fbmd_pkg::power_t pa_s2, pb_s2;
	fbmd_pkg::level_t lvl_a, lvl_b;

	// config port: floor register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'(fbmd_pkg::FLOOR_RESET);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				fbmd_pkg::REG_FLOOR_DB: floor_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fbmd_pkg::REG_FLOOR_DB: prdata = 32'(floor_q);
			default:                prdata = '0;
		endcase
	end

	// stage enables: a stage loads when empty or when the one after it moves
	assign last_c      = !stg_meta_s[NSTG].pair0 || sec_q;
	assign take_last_c = stg_vld_s[NSTG] && data_out.ready && last_c;

	always_comb begin
		stg_en[NSTG] = !stg_vld_s[NSTG] || take_last_c;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stg_en[k] = !stg_vld_s[k] || stg_en[k+1];
		end
	end

	assign data_in.ready = stg_en[1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_s <= '0;
		end else begin
			if (stg_en[1]) stg_vld_s[1] <= data_in.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (stg_en[k]) stg_vld_s[k] <= stg_vld_s[k-1];
			end
		end
	end

	// bin tags travel beside the data
	assign meta_in_c.pair0 = (data_in.pair_index == '0);
	assign meta_in_c.bin   = {1'b0, data_in.pair_index};

	always_ff @(posedge clk) begin
		if (stg_en[1]) stg_meta_s[1] <= meta_in_c;
		for (int k = 2; k <= NSTG; k++) begin
			if (stg_en[k]) stg_meta_s[k] <= stg_meta_s[k-1];
		end
	end

	// squares of both parts
	assign pr_c = 64'(data_in.real_part) * 64'(data_in.real_part);
	assign pi_c = 64'(data_in.imag_part) * 64'(data_in.imag_part);

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			pr_s1 <= fbmd_pkg::power_t'(pr_c);
			pi_s1 <= fbmd_pkg::power_t'(pi_c);
		end
	end

	// lane a: dc term or bin power, lane b: nyquist term
	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			pa_s2 <= stg_meta_s[1].pair0 ? pr_s1 : pr_s1 + pi_s1;
			pb_s2 <= pi_s1;
		end
	end

	fbmd_lane #(.OFFSET_Q16(OFFSET_Q16)) u_lane_a (
		.clk      (clk),
		.en       (stg_en[NSTG:3]),
		.power    (pa_s2),
		.floor_db (floor_q),
		.level    (lvl_a)
	);

	fbmd_lane #(.OFFSET_Q16(OFFSET_Q16)) u_lane_b (
		.clk      (clk),
		.en       (stg_en[NSTG:3]),
		.power    (pb_s2),
		.floor_db (floor_q),
		.level    (lvl_b)
	);

	// output beat select; pair 0 gives a second beat for the nyquist bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= 1'b0;
		end else if (stg_vld_s[NSTG] && data_out.ready) begin
			sec_q <= !last_c;
		end
	end

	assign data_out.valid        = stg_vld_s[NSTG];
	assign data_out.last_of_item = last_c;
	assign data_out.bin_index    = stg_meta_s[NSTG].pair0 ?
		(sec_q ? HALF_BIN : '0) : stg_meta_s[NSTG].bin;
	assign data_out.level_db     = (stg_meta_s[NSTG].pair0 && sec_q) ? lvl_b : lvl_a;

	// checks
	`ASSERT_IMPL(a_sec_only_pair0, clk, arst_n, sec_q, stg_vld_s[NSTG] && stg_meta_s[NSTG].pair0, "second beat without a pair-0 item")
	`ASSERT_NEXT(a_nyquist_follows, clk, arst_n, data_out.valid && data_out.ready && !data_out.last_of_item, data_out.valid && data_out.last_of_item && data_out.bin_index == HALF_BIN, "nyquist beat missing after dc beat")
	`ASSERT_NEXT(a_accept_fills, clk, arst_n, data_in.valid && data_in.ready, stg_vld_s[1], "accepted beat not captured in first stage")

endmodule

// ===== bench/tb_fft_bin_magnitude_db.sv =====
// testbench for the fft bin level meter: directed and random pairs checked against a local predictor
`timescale 1ns / 1ps

module tb_fft_bin_magnitude_db;

	localparam int FRAME_LEN   = 1024;
	localparam int FRAC_BITS   = 15;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam longint DB_SCALE_Q16 = 197283;
	localparam fbmd_pkg::bin_t NYQUIST_BIN = fbmd_pkg::bin_t'(FRAME_LEN / 2);
	localparam logic [2:0] ADDR_FLOOR    = 3'(4 * fbmd_pkg::REG_FLOOR_DB);
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
	localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

	// log2(1+i/16) in Q16 at each segment knot
	localparam longint LOG2_KNOT [17] = '{
		0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
		38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
	};

	typedef struct {
		fbmd_pkg::bin_t   bin;
		fbmd_pkg::level_t level;
		logic             last;
	} bin_level_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fbmd_in_if  in_bus ();
	fbmd_out_if out_bus ();

	bin_level_t level_queue[$];
	fbmd_pkg::level_t floor_level;
	bit steady;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	fft_bin_magnitude_db #(
		.FRAME_LEN(FRAME_LEN),
		.SAMPLE_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_in(in_bus),
		.data_out(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fft_bin_magnitude_db test failed");
			$finish;
		end
	end

	// result side backpressure
	always @(posedge clk) begin
		out_bus.ready <= steady || ($urandom_range(0, 99) >= 33);
	end

	// log2 of a nonzero value in unsigned Q16, leading one plus table interpolation
	function automatic longint log2_fix(input logic [63:0] v);
		int pos;
		logic [63:0] norm;
		logic [3:0] seg;
		longint rem;
		pos = 0;
		for (int b = 0; b < 64; b++) begin
			if (v[b]) pos = b;
		end
		norm = v << (63 - pos);
		seg = norm[62:59];
		rem = norm[58:43];
		return (longint'(pos) << 16) + LOG2_KNOT[seg] +
			(((LOG2_KNOT[seg + 1] - LOG2_KNOT[seg]) * rem) >>> 16);
	endfunction

	// power to Q8.8 dBFS, floored and clamped
	function automatic fbmd_pkg::level_t dbfs_of_power(input logic [63:0] power);
		longint net;
		longint lvl;
		longint fl;
		fl = floor_level;
		if (power == 64'd0) begin
			lvl = fl;
		end else begin
			net = log2_fix(power) - (longint'(2 * FRAC_BITS) * 65536 +
				2 * log2_fix(64'(FRAME_LEN / 2)));
			lvl = (net * DB_SCALE_Q16 + 64'sd8388608) >>> 24;
			if (lvl < fl) lvl = fl;
		end
		if (lvl > 32767) lvl = 32767;
		return lvl[15:0];
	endfunction

	// expected levels for one accepted pair
	task automatic predict_levels(input logic signed [31:0] re, input logic signed [31:0] im,
		input logic [8:0] pair);
		longint re_w;
		longint im_w;
		logic [63:0] re_sq;
		logic [63:0] im_sq;
		bin_level_t lv;
		re_w = re;
		im_w = im;
		re_sq = re_w * re_w;
		im_sq = im_w * im_w;
		if (pair == 9'd0) begin
			lv.bin = '0;
			lv.level = dbfs_of_power(re_sq);
			lv.last = 1'b0;
			level_queue.push_back(lv);
			lv.bin = NYQUIST_BIN;
			lv.level = dbfs_of_power(im_sq);
			lv.last = 1'b1;
			level_queue.push_back(lv);
		end else begin
			lv.bin = {1'b0, pair};
			lv.level = dbfs_of_power(re_sq + im_sq);
			lv.last = 1'b1;
			level_queue.push_back(lv);
		end
	endtask

	// compare each result beat with the oldest expected level
	always @(posedge clk) begin
		bin_level_t exp_lv;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (level_queue.size() == 0) begin
				$error("unexpected result beat: bin_index %0d level_db %0d",
					out_bus.bin_index, out_bus.level_db);
				error_count++;
			end else begin
				exp_lv = level_queue.pop_front();
				if (out_bus.bin_index !== exp_lv.bin) begin
					$error("bin_index: expected %0d, got %0d", exp_lv.bin, out_bus.bin_index);
					error_count++;
				end
				if (out_bus.level_db !== exp_lv.level) begin
					$error("level_db: expected %0d, got %0d (bin %0d)",
						exp_lv.level, out_bus.level_db, exp_lv.bin);
					error_count++;
				end
				if (out_bus.last_of_item !== exp_lv.last) begin
					$error("last_of_item: expected %0d, got %0d (bin %0d)",
						exp_lv.last, out_bus.last_of_item, exp_lv.bin);
					error_count++;
				end
			end
		end
	end

	// send one pair beat, at times with a random gap ahead of it
	task automatic send_pair(input logic signed [31:0] re, input logic signed [31:0] im,
		input logic [8:0] pair);
		if (!steady && $urandom_range(0, 99) < 33) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.real_part <= re;
		in_bus.imag_part <= im;
		in_bus.pair_index <= pair;
		do @(posedge clk); while (!in_bus.ready);
		predict_levels(re, im, pair);
	endtask

	// stop sending and wait for every expected level, then let the pipeline settle
	task automatic drain_results();
		in_bus.valid <= 1'b0;
		while (level_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_FLOOR) floor_level = data[15:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read the floor register back
	task automatic check_floor_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FLOOR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== floor_level) begin
			$error("floor_db: expected %0d, got %0d", floor_level, $signed(prdata[15:0]));
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_floor(input fbmd_pkg::level_t value);
		drain_results();
		apb_write(ADDR_FLOOR, {{16{value[15]}}, value});
		check_floor_readback();
	endtask

	// random sample: mostly spread over all magnitudes, some zeros and extremes
	function automatic logic signed [31:0] random_sample();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return SAMPLE_MIN;
			2: return SAMPLE_MAX;
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	// default floor after reset, field extremes, zero power, levels around the floor
	task automatic test_reset_floor();
		check_floor_readback();
		send_pair(32'sd0, 32'sd0, 9'd0);
		send_pair(SAMPLE_MIN, SAMPLE_MAX, 9'd0);
		send_pair(SAMPLE_MIN, SAMPLE_MIN, 9'd511);
		send_pair(SAMPLE_MAX, SAMPLE_MAX, 9'd1);
		send_pair(32'sd0, 32'sd0, 9'd200);
		send_pair(32'sd1, -32'sd1, 9'd2);
		send_pair(32'sd170, -32'sd3, 9'd3);
		send_pair(-32'sd32768, 32'sd12345, 9'd256);
		send_pair(32'sd0, 32'sd1, 9'd0);
	endtask

	// lowest, zero and positive floors, and a write outside the register map
	task automatic test_floor_extremes();
		fbmd_pkg::level_t floors [4];
		floors = '{16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh0100};
		foreach (floors[f]) begin
			set_floor(floors[f]);
			if (f == 3) begin
				apb_write(ADDR_UNMAPPED, 32'hFFFF_8000);
				check_floor_readback();
			end
			send_pair(32'sd1, 32'sd0, 9'd5);
			send_pair(SAMPLE_MIN, 32'sd0, 9'd0);
			send_pair(32'sd300, -32'sd300, 9'd511);
			send_pair(32'sd0, 32'sd0, 9'd9);
		end
	endtask

	// frames of consecutive pairs with random content, some stray pairs, random floors
	task automatic test_random_frames();
		int sent;
		int frame_len;
		fbmd_pkg::level_t fl;
		sent = 0;
		for (int chunk = 0; chunk < 4; chunk++) begin
			fl = fbmd_pkg::level_t'(-$signed(17'($urandom_range(0, 32768))));
			if (chunk == 0) fl = fbmd_pkg::level_t'(fbmd_pkg::FLOOR_RESET);
			set_floor(fl);
			while (sent < (chunk + 1) * 263) begin
				if ($urandom_range(0, 9) == 0) begin
					steady = (sent >= 400 && sent < 600);
					send_pair(random_sample(), random_sample(), 9'($urandom_range(0, 511)));
					sent++;
				end else begin
					frame_len = $urandom_range(4, 24);
					for (int k = 0; k < frame_len; k++) begin
						steady = (sent >= 400 && sent < 600);
						send_pair(random_sample(), random_sample(), 9'(k));
						sent++;
					end
				end
				// hold off in one window of the run until the pipeline has emptied
				if (sent >= 800 && sent < 830) begin
					in_bus.valid <= 1'b0;
					while (level_queue.size() != 0) @(posedge clk);
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_bus.valid <= 1'b0;
		in_bus.real_part <= '0;
		in_bus.imag_part <= '0;
		in_bus.pair_index <= '0;
		steady = 1'b0;
		floor_level = fbmd_pkg::level_t'(fbmd_pkg::FLOOR_RESET);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_floor();
		test_floor_extremes();
		test_random_frames();
		drain_results();

		if (error_count == 0) begin
			$display("fft_bin_magnitude_db test passed");
		end else begin
			$display("fft_bin_magnitude_db test failed");
		end
		$finish;
	end

endmodule
